@@ rtl/core/oab_pkg.sv @@
// Package of shared types and constants for the object identifier arc encoder.
`timescale 1ns / 1ps

package oab_pkg;

  // Width of one incoming arc value.
  localparam int unsigned ARC_W = 32;
  // Width of first*40 and of first*40 + second.
  localparam int unsigned HELD_W = 38;
  localparam int unsigned COMB_W = 39;
  // Width of one base-128 group and of one output byte.
  localparam int unsigned GROUP_W = 7;
  localparam int unsigned BYTE_W = 8;

  // Position of the next arc inside the identifier.
  typedef enum logic [1:0] {
    POS_FIRST,
    POS_SECOND,
    POS_LATER
  } oab_pos_t;

  // Status of the queue between the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } oab_qstat_t;

endpackage

@@ rtl/core/oid_arc_base128_encoder.sv @@
// Top level of the object identifier arc encoder.
`timescale 1ns / 1ps
// Object identifier arcs enter one beat at a time on the arc channel
// (arc_valid, arc_stall, arc_value, last_arc); the final arc of an identifier
// has last_arc set. Encoded contents bytes leave on the byte channel
// (byte_valid, byte_stall, out_byte, arc_end, oid_end, arc_error).
// The first arc is held and sends nothing; the second is combined as
// first*40 + second; later arcs are sent as they are. Each value goes out as
// one to MAX_GROUPS bytes, most significant group first. A value too wide, or
// an identifier of one arc, gives a single zero byte with arc_error set.
// With the back part idle, an accepted arc is written into the queue and then
// loaded into the value register of the back part, which offers its first byte.
// Each arc leaves as one to MAX_GROUPS bytes, sent back to back on the single
// byte-wide output channel of the back part unless byte_stall holds them;
// the arc channel takes one beat a cycle while the two-entry queue has room.
// Reset clears the arc position, the queue and the valid flag of the output;
// no byte is valid after reset. While byte_stall is high the current byte holds,
// the queue fills, and arc_stall rises once both entries are taken.

module oid_arc_base128_encoder #(
  parameter int unsigned MAX_GROUPS = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       arc_valid,
  output logic                       arc_stall,
  input  logic [oab_pkg::ARC_W-1:0]  arc_value,
  input  logic                       last_arc,
  output logic                       byte_valid,
  input  logic                       byte_stall,
  output logic [oab_pkg::BYTE_W-1:0] out_byte,
  output logic                       arc_end,
  output logic                       oid_end,
  output logic                       arc_error
);

  localparam int unsigned VW = oab_pkg::GROUP_W * MAX_GROUPS;
  localparam int unsigned EW = (oab_pkg::COMB_W > VW) ? oab_pkg::COMB_W : VW;

  oab_pkg::oab_qstat_t qst;
  logic                q_push;
  logic                q_pop;
  logic [VW+1:0]       q_wdata;
  logic [VW+1:0]       q_rdata;

  oab_front #(
    .VW (VW),
    .EW (EW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .arc_valid (arc_valid),
    .arc_stall (arc_stall),
    .arc_value (arc_value),
    .last_arc  (last_arc),
    .qst       (qst),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  oab_queue #(
    .W (VW + 2)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .qst   (qst)
  );

  oab_back #(
    .MG (MAX_GROUPS),
    .VW (VW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_data     (q_rdata),
    .qst        (qst),
    .q_pop      (q_pop),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .out_byte   (out_byte),
    .arc_end    (arc_end),
    .oid_end    (oid_end),
    .arc_error  (arc_error)
  );

  // The queue is never full and empty at once.
  a_queue_state: assert property (@(posedge clk) disable iff (rst)
    !(qst.full && qst.empty))
    else $error("queue reports full and empty together");

  // The end of an identifier is always the end of an arc.
  a_oid_arc_end: assert property (@(posedge clk) disable iff (rst)
    byte_valid && oid_end |-> arc_end)
    else $error("oid_end without arc_end");

  // An error result carries a zero byte.
  a_error_byte: assert property (@(posedge clk) disable iff (rst)
    byte_valid && arc_error |-> (out_byte == '0) && arc_end)
    else $error("error result with non-zero byte");

  // A byte with more to follow is followed at once by the next byte.
  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_stall && !arc_end |=> byte_valid)
    else $error("byte run broken");

endmodule

@@ rtl/core/oab_front.sv @@
// Front part: accepts arcs, combines the first two and classifies each value.
`timescale 1ns / 1ps

module oab_front #(
  parameter int unsigned VW = 28,
  parameter int unsigned EW = 39
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        arc_valid,
  output logic                        arc_stall,
  input  logic [oab_pkg::ARC_W-1:0]   arc_value,
  input  logic                        last_arc,
  input  oab_pkg::oab_qstat_t         qst,
  output logic                        q_push,
  output logic [VW+1:0]               q_data
);

  oab_pkg::oab_pos_t               pos, pos_next;
  logic [oab_pkg::HELD_W-1:0]      held40, held40_next;
  logic [EW-1:0]                   ext;
  logic [oab_pkg::COMB_W-1:0]      comb_sum;
  logic                            accept;
  logic                            too_wide;
  logic                            err;

  assign arc_stall = qst.full;
  assign accept    = arc_valid && !qst.full;

  // first*40 + second, with first*40 held from the previous beat.
  assign comb_sum = oab_pkg::COMB_W'(held40) + oab_pkg::COMB_W'(arc_value);

  // State register and the held product.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= oab_pkg::POS_FIRST;
    end else begin
      pos <= pos_next;
    end
    held40 <= held40_next;
  end

  // Next position, value selection and queue write.
  always_comb begin
    pos_next    = pos;
    held40_next = held40;
    q_push      = 1'b0;
    ext         = '0;
    err         = 1'b0;
    case (pos)
      oab_pkg::POS_FIRST: begin
        if (accept) begin
          held40_next = {1'b0, arc_value, 5'b0} + {3'b0, arc_value, 3'b0};
          if (last_arc) begin
            // An identifier of one arc gives one error result.
            q_push = 1'b1;
            err    = 1'b1;
          end else begin
            pos_next = oab_pkg::POS_SECOND;
          end
        end
      end
      oab_pkg::POS_SECOND: begin
        ext = EW'(comb_sum);
        if (accept) begin
          q_push   = 1'b1;
          pos_next = last_arc ? oab_pkg::POS_FIRST : oab_pkg::POS_LATER;
        end
      end
      default: begin
        ext = EW'(arc_value);
        if (accept) begin
          q_push   = 1'b1;
          pos_next = last_arc ? oab_pkg::POS_FIRST : oab_pkg::POS_LATER;
        end
      end
    endcase
  end

  // A value wider than the group limit becomes an error entry of value zero.
  assign too_wide = (ext >> VW) != '0;

  always_comb begin
    if (err || too_wide) begin
      q_data = {1'b1, last_arc, {VW{1'b0}}};
    end else begin
      q_data = {1'b0, last_arc, ext[VW-1:0]};
    end
  end

endmodule

@@ rtl/core/oab_queue.sv @@
// Two-entry queue that decouples the front and back parts.
`timescale 1ns / 1ps

module oab_queue #(
  parameter int unsigned W = 30
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [W-1:0]         wdata,
  input  logic                 pop,
  output logic [W-1:0]         rdata,
  output oab_pkg::oab_qstat_t  qst
);

  logic [W-1:0] entry [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;

  assign qst.full  = (count == 2'd2);
  assign qst.empty = (count == 2'd0);
  assign rdata     = entry[rptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= wdata;
    end
  end

endmodule

@@ rtl/core/oab_back.sv @@
// Back part: sends each queued value as base-128 bytes, most significant first.
`timescale 1ns / 1ps

module oab_back #(
  parameter int unsigned MG = 4,
  parameter int unsigned VW = 28
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [VW+1:0]              q_data,
  input  oab_pkg::oab_qstat_t        qst,
  output logic                       q_pop,
  output logic                       byte_valid,
  input  logic                       byte_stall,
  output logic [oab_pkg::BYTE_W-1:0] out_byte,
  output logic                       arc_end,
  output logic                       oid_end,
  output logic                       arc_error
);

  localparam int unsigned IW = (MG > 1) ? $clog2(MG) : 1;

  logic                         have;
  logic [VW-1:0]                val;
  logic                         last;
  logic                         err;
  logic [IW-1:0]                idx;
  logic [IW-1:0]                top_grp;
  logic [oab_pkg::GROUP_W-1:0]  grp;
  logic                         fire;
  logic                         done;

  assign fire  = have && !byte_stall;
  assign done  = !have || (fire && (idx == '0));
  assign q_pop = done && !qst.empty;

  // Index of the highest non-zero group of the value at the queue head.
  always_comb begin
    top_grp = '0;
    for (int g = 1; g < MG; g++) begin
      if (q_data[oab_pkg::GROUP_W*g +: oab_pkg::GROUP_W] != '0) begin
        top_grp = IW'(g);
      end
    end
  end

  // Group selected for the current byte.
  always_comb begin
    grp = '0;
    for (int g = 0; g < MG; g++) begin
      if (idx == IW'(g)) begin
        grp = val[oab_pkg::GROUP_W*g +: oab_pkg::GROUP_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (done) begin
      have <= !qst.empty;
    end
  end

  // Load the next value when idle or as the last byte of the current one goes out.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      val  <= q_data[VW-1:0];
      last <= q_data[VW];
      err  <= q_data[VW+1];
      idx  <= top_grp;
    end else if (fire) begin
      idx <= idx - IW'(1);
    end
  end

  assign byte_valid = have;
  assign arc_end    = (idx == '0);
  assign oid_end    = last && (idx == '0);
  assign arc_error  = err;
  assign out_byte   = {(idx != '0), grp};

endmodule
